// File: rtl/weekday_time_counter_defines.svh
// Assertion macros used by the weekday time counter RTL.
`ifndef WEEKDAY_TIME_COUNTER_DEFINES_SVH
`define WEEKDAY_TIME_COUNTER_DEFINES_SVH

// Plain property, checked on every rising clock edge outside reset.
`define WTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication within the same cycle, checked outside reset.
`define WTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/wtc_pkg.sv
// Types, constants and command decoding for the weekday time counter.
`default_nettype none

package wtc_pkg;

  localparam int CARRY_W = 16;

  localparam int MS_MOD   = 1000;
  localparam int SEC_MOD  = 60;
  localparam int MIN_MOD  = 60;
  localparam int HOUR_MOD = 24;
  localparam int DAY_MOD  = 7;

  localparam int MS_W   = 10;
  localparam int SEC_W  = 6;
  localparam int MIN_W  = 6;
  localparam int HOUR_W = 5;
  localparam int DAY_W  = 3;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_SET_HM   = 2'd1,
    CMD_SET_FULL = 2'd2,
    CMD_SET_WD   = 2'd3
  } cmd_e;

  // What one cell does with its field for a given request.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_LOAD,
    OP_CLEAR,
    OP_KEEP
  } cell_op_e;

  typedef enum logic [2:0] {
    LANE_MS,
    LANE_SEC,
    LANE_MIN,
    LANE_HOUR,
    LANE_DAY
  } lane_e;

  typedef struct packed {
    cmd_e               command;
    logic [15:0]        delta_ms;
    logic [DAY_W-1:0]   set_weekday;
    logic [HOUR_W-1:0]  set_hour;
    logic [MIN_W-1:0]   set_minute;
    logic [SEC_W-1:0]   set_second;
  } in_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   weekday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MS_W-1:0]    millisecond;
  } out_rsp_t;

  // One request as it travels down the chain of cells.
  typedef struct packed {
    cmd_e               command;
    logic [CARRY_W-1:0] carry;
    logic [DAY_W-1:0]   set_weekday;
    logic [HOUR_W-1:0]  set_hour;
    logic [MIN_W-1:0]   set_minute;
    logic [SEC_W-1:0]   set_second;
    out_rsp_t           res;
  } stage_t;

  function automatic cell_op_e cell_op(lane_e lane, cmd_e cmd);
    cell_op_e op;
    op = OP_KEEP;
    if (cmd == CMD_ADD) begin
      op = OP_ADD;
    end else begin
      unique case (lane)
        LANE_MS: begin
          op = (cmd == CMD_SET_WD) ? OP_KEEP : OP_CLEAR;
        end
        LANE_SEC: begin
          unique case (cmd)
            CMD_SET_HM:   op = OP_CLEAR;
            CMD_SET_FULL: op = OP_LOAD;
            default:      op = OP_KEEP;
          endcase
        end
        LANE_MIN, LANE_HOUR: begin
          op = (cmd == CMD_SET_WD) ? OP_KEEP : OP_LOAD;
        end
        LANE_DAY: begin
          op = (cmd == CMD_SET_HM) ? OP_KEEP : OP_LOAD;
        end
        default: op = OP_KEEP;
      endcase
    end
    return op;
  endfunction

endpackage

`default_nettype wire

// File: rtl/weekday_time_counter.sv
// Top level of the weekday time counter: a five-cell carry chain with flow control.
//
//   channel   direction  handshake                  payload
//   request   in         in_valid_i / in_stall_o    in_req_i  (in_req_t)
//   response  out        out_valid_o / out_stall_i  out_rsp_o (out_rsp_t)
//
// Each request passes five cells, millisecond, second, minute, hour and
// weekday, in that order, with a stage register behind each cell.
// A new request enters every cycle while in_stall_o is low; each cell updates its own field as the
// request passes it, so every request sees the fields left by the one before.
// The last stage register is the output register.
// Reset clears every field to zero (00:00:00.000 on weekday 0) and empties the chain.
// A stall on the response side only backs up into the request side once
// all five stages hold a request; empty stages close up first.
`default_nettype none
`include "weekday_time_counter_defines.svh"

module weekday_time_counter
  import wtc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int NumStages = 5;

  // Stage k holds a request after it has passed cell k.
  logic   [NumStages-1:0] valid_q;
  stage_t                 stage_q [NumStages];
  stage_t                 stage_d [NumStages];
  stage_t                 head;

  // rdy[k]: stage k can take a request this cycle. en[k]: it does.
  logic   [NumStages-1:0] rdy;
  logic   [NumStages-1:0] en;
  logic   [NumStages-1:0] feed_valid;

  logic [MS_W-1:0]    ms_val;
  logic [SEC_W-1:0]   sec_val;
  logic [MIN_W-1:0]   min_val;
  logic [HOUR_W-1:0]  hour_val;
  logic [DAY_W-1:0]   day_val;
  logic [CARRY_W-1:0] ms_carry, sec_carry, min_carry, hour_carry;

  // The incoming request enters the chain with its delta as the first carry.
  always_comb begin
    head             = '0;
    head.command     = in_req_i.command;
    head.carry       = in_req_i.delta_ms;
    head.set_weekday = in_req_i.set_weekday;
    head.set_hour    = in_req_i.set_hour;
    head.set_minute  = in_req_i.set_minute;
    head.set_second  = in_req_i.set_second;
  end

  // Flow control: a full stage frees up when the stage after it takes its request.
  always_comb begin
    rdy[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    feed_valid[0] = in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      feed_valid[k] = valid_q[k-1];
    end
    en = feed_valid & rdy;
  end

  assign in_stall_o = !rdy[0];

  wtc_cell #(.Mod(MS_MOD), .FieldW(MS_W)) u_ms_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .op_i    (cell_op(LANE_MS, head.command)),
    .load_i  ('0),
    .carry_i (head.carry),
    .field_o (ms_val),
    .carry_o (ms_carry)
  );

  wtc_cell #(.Mod(SEC_MOD), .FieldW(SEC_W)) u_sec_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[1]),
    .op_i    (cell_op(LANE_SEC, stage_q[0].command)),
    .load_i  (stage_q[0].set_second),
    .carry_i (stage_q[0].carry),
    .field_o (sec_val),
    .carry_o (sec_carry)
  );

  wtc_cell #(.Mod(MIN_MOD), .FieldW(MIN_W)) u_min_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[2]),
    .op_i    (cell_op(LANE_MIN, stage_q[1].command)),
    .load_i  (stage_q[1].set_minute),
    .carry_i (stage_q[1].carry),
    .field_o (min_val),
    .carry_o (min_carry)
  );

  wtc_cell #(.Mod(HOUR_MOD), .FieldW(HOUR_W)) u_hour_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[3]),
    .op_i    (cell_op(LANE_HOUR, stage_q[2].command)),
    .load_i  (stage_q[2].set_hour),
    .carry_i (stage_q[2].carry),
    .field_o (hour_val),
    .carry_o (hour_carry)
  );

  // The weekday wraps at seven and passes no carry on.
  wtc_cell #(.Mod(DAY_MOD), .FieldW(DAY_W)) u_day_cell (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[4]),
    .op_i    (cell_op(LANE_DAY, stage_q[3].command)),
    .load_i  (stage_q[3].set_weekday),
    .carry_i (stage_q[3].carry),
    .field_o (day_val),
    .carry_o ()
  );

  // Each stage records its cell's new field and hands the carry onward.
  always_comb begin
    stage_d[0]                  = head;
    stage_d[0].carry            = ms_carry;
    stage_d[0].res.millisecond  = ms_val;

    stage_d[1]                  = stage_q[0];
    stage_d[1].carry            = sec_carry;
    stage_d[1].res.second       = sec_val;

    stage_d[2]                  = stage_q[1];
    stage_d[2].carry            = min_carry;
    stage_d[2].res.minute       = min_val;

    stage_d[3]                  = stage_q[2];
    stage_d[3].carry            = hour_carry;
    stage_d[3].res.hour         = hour_val;

    stage_d[4]                  = stage_q[3];
    stage_d[4].res.weekday      = day_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= feed_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign out_rsp_o   = stage_q[NumStages-1].res;

  // The chain only pushes back once every stage is occupied.
  `WTC_ASSERT_IMPL(a_stall_only_full, clk_i, rst_ni, in_stall_o, &valid_q,
    "request side stalled while the chain has an empty stage")
  // After an add the millisecond is in range and the second carry is small.
  `WTC_ASSERT_IMPL(a_ms_range, clk_i, rst_ni,
    valid_q[0] && (stage_q[0].command == CMD_ADD),
    (stage_q[0].res.millisecond < 10'd1000) && (stage_q[0].carry < 16'd67),
    "millisecond cell left an out-of-range value or carry")
  // After an add the weekday, hour, minute and second of the response are back in range.
  `WTC_ASSERT_IMPL(a_add_normalized, clk_i, rst_ni,
    out_valid_o && (stage_q[NumStages-1].command == CMD_ADD),
    (out_rsp_o.weekday < 3'd7) && (out_rsp_o.hour < 5'd24) &&
    (out_rsp_o.minute < 6'd60) && (out_rsp_o.second < 6'd60),
    "add request produced an out-of-range time")
  // A request taken at the head reaches the first stage.
  `WTC_ASSERT(a_head_fill, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> valid_q[0],
    "accepted request did not enter the first stage")

endmodule

`default_nettype wire

// File: rtl/wtc_cell.sv
// One digit cell of the time counter: holds a field and splits field plus carry.
`default_nettype none

module wtc_cell
  import wtc_pkg::*;
#(
  parameter int Mod    = MS_MOD,
  parameter int FieldW = MS_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cell_op_e           op_i,
  input  logic [FieldW-1:0]  load_i,
  input  logic [CARRY_W-1:0] carry_i,
  output logic [FieldW-1:0]  field_o,
  output logic [CARRY_W-1:0] carry_o
);

  localparam int SumW  = CARRY_W + 1;
  localparam int Shift = SumW + $clog2(Mod);
  localparam int ProdW = SumW + Shift;
  // Rounded-up reciprocal; exact quotient for every sum below 2**SumW.
  localparam logic [ProdW-1:0] Recip =
    ProdW'(((64'd1 << Shift) + 64'(Mod) - 64'd1) / 64'(Mod));

  logic [FieldW-1:0] field_q, field_d;
  logic [SumW-1:0]   sum;
  logic [ProdW-1:0]  prod;
  logic [SumW-1:0]   quot;
  logic [SumW-1:0]   rem;

  assign sum  = SumW'(field_q) + SumW'(carry_i);
  assign prod = ProdW'(sum) * Recip;
  assign quot = prod[Shift +: SumW];
  assign rem  = sum - (quot * SumW'(Mod));

  always_comb begin
    case (op_i)
      OP_ADD:   field_d = rem[FieldW-1:0];
      OP_LOAD:  field_d = load_i;
      OP_CLEAR: field_d = '0;
      default:  field_d = field_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '0;
    end else if (en_i) begin
      field_q <= field_d;
    end
  end

  assign field_o = field_d;
  assign carry_o = quot[CARRY_W-1:0];

endmodule

`default_nettype wire
